// ----- src/drcs_pkg.sv -----
// Package for the distance range constraint solver.
// Holds the request and response structs, field widths, register indices and status codes.
// No dependencies.
package drcs_pkg;

  localparam int PosWidth    = 32;
  localparam int MassWidth   = 32;
  localparam int StiffWidth  = 17;
  localparam int DistWidth   = 32;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 32;

  localparam logic [StiffWidth-1:0] StiffOne = 17'h10000;

  localparam logic [CfgIdxWidth-1:0] CfgStiffness   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMinDistance = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgMaxDistance = 2'd2;

  typedef enum logic [1:0] {
    StatusInRange    = 2'd0,
    StatusStretched  = 2'd1,
    StatusCompressed = 2'd2,
    StatusDegenerate = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [PosWidth-1:0] a_x;
    logic signed [PosWidth-1:0] a_y;
    logic signed [PosWidth-1:0] a_z;
    logic signed [PosWidth-1:0] b_x;
    logic signed [PosWidth-1:0] b_y;
    logic signed [PosWidth-1:0] b_z;
    logic [MassWidth-1:0]       a_inv_mass;
    logic [MassWidth-1:0]       b_inv_mass;
  } in_req_t;

  typedef struct packed {
    logic signed [PosWidth-1:0] new_a_x;
    logic signed [PosWidth-1:0] new_a_y;
    logic signed [PosWidth-1:0] new_a_z;
    logic signed [PosWidth-1:0] new_b_x;
    logic signed [PosWidth-1:0] new_b_y;
    logic signed [PosWidth-1:0] new_b_z;
    logic [1:0]                 status;
  } out_rsp_t;

endpackage

// ----- src/drcs_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// The caller guarantees the quotient fits in QuoW bits. No dependencies.
module drcs_div_pipe #(
  parameter int NumW = 49,
  parameter int DenW = 33,
  parameter int QuoW = 17
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [DenW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DenW-1:0] rem_in;
    logic [QuoW-1:0] low_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      // The high part is below the divisor because the quotient fits.
      assign rem_in = DenW'(num_i >> QuoW);
      assign low_in = num_i[QuoW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QuoW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        low_q[k] <= low_in << 1;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QuoW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

// ----- src/distance_range_constraint_solver.sv -----
// Top level of the distance range constraint solver.
// Uses drcs_pkg and drcs_div_pipe.
//
//   port group   direction  handshake                payload
//   in           in         in_valid_i / in_ready_o   in_req_i  (drcs_pkg::in_req_t)
//   out          out        out_valid_o / out_ready_i out_rsp_o (drcs_pkg::out_rsp_t)
//   cfg          in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request enters per cycle while in_ready_o is high. A request passes through
// the bit-per-stage square root (33 stages), then the range check and products,
// then the bit-per-stage correction dividers (33 stages). Reset clears the valid
// bits and loads the register defaults. When a result waits and out_ready_i
// is low, the whole pipeline holds and in_ready_o drops; nothing is lost.
module distance_range_constraint_solver (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  drcs_pkg::in_req_t                      in_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output drcs_pkg::out_rsp_t                     out_rsp_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [drcs_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [drcs_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  localparam int PosW   = drcs_pkg::PosWidth;
  localparam int MassW  = drcs_pkg::MassWidth;
  localparam int StiffW = drcs_pkg::StiffWidth;
  localparam int DistW  = drcs_pkg::DistWidth;
  localparam int MagW   = PosW + 1;
  localparam int SqW    = 2 * MagW;
  localparam int TrW    = SqW + 1;
  localparam int RootW  = PosW + 1;
  localparam int ErrW   = RootW;
  localparam int ProdW  = MagW + ErrW;
  localparam int NumW   = ProdW + StiffW;
  localparam int DenW   = RootW + 16;
  localparam int QW     = ErrW;
  localparam int SaNumW = StiffW + MassW;
  localparam int SaDenW = MassW + 1;
  localparam int SaQW   = StiffW;
  localparam int ExtW   = PosW + 3;

  // Stage numbers: stage t is the register written at the t-th pipeline advance, counting acceptance.
  localparam int TRoot  = 4 + RootW;
  localparam int TE     = TRoot + 1;
  localparam int TG     = TE + 2;
  localparam int TQ     = TG + QW;
  localparam int NStage = TQ + 1;
  localparam int TSaOut = 2 + SaQW;

  typedef struct packed {
    logic [2:0][PosW-1:0] pa;
    logic [2:0][PosW-1:0] pb;
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 mz;
  } side_t;

  typedef struct packed {
    drcs_pkg::status_e status;
    logic              grow;
    logic              apply;
  } meta_t;

  // Configuration registers.
  logic [StiffW-1:0] stiff_q;
  logic [DistW-1:0]  min_q, max_q;
  logic [StiffW-1:0] s_cl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= drcs_pkg::StiffOne;
      min_q   <= '0;
      max_q   <= DistW'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        drcs_pkg::CfgStiffness:   stiff_q <= cfg_data_i[StiffW-1:0];
        drcs_pkg::CfgMinDistance: min_q   <= cfg_data_i[DistW-1:0];
        drcs_pkg::CfgMaxDistance: max_q   <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  assign s_cl = (stiff_q > drcs_pkg::StiffOne) ? drcs_pkg::StiffOne : stiff_q;

  // Pipeline control: a single advance enable for every stage.
  logic              en;
  logic [NStage:1]   v_q;

  assign en          = !v_q[NStage] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStage-1:1], in_valid_i};
    end
  end

  // Stage 1: request register.
  drcs_pkg::in_req_t in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_req_i;
    end
  end

  // Stage 2: separation, magnitudes and the mass split operands.
  side_t                   side_d;
  side_t                   side_q [2:TQ];
  logic [SaNumW-1:0]       sa_num_q;
  logic [SaDenW-1:0]       sa_den_q;
  logic [2:0][PosW-1:0]    a_c, b_c;
  logic signed [MagW-1:0]  dlt [3];

  always_comb begin
    a_c = {in_q.a_z, in_q.a_y, in_q.a_x};
    b_c = {in_q.b_z, in_q.b_y, in_q.b_x};
    side_d.pa = a_c;
    side_d.pb = b_c;
    for (int i = 0; i < 3; i++) begin
      dlt[i] = $signed({a_c[i][PosW-1], a_c[i]}) - $signed({b_c[i][PosW-1], b_c[i]});
      side_d.neg[i] = dlt[i][MagW-1];
      side_d.mag[i] = dlt[i][MagW-1] ? MagW'(-dlt[i]) : MagW'(dlt[i]);
    end
    side_d.mz = (in_q.a_inv_mass == '0) && (in_q.b_inv_mass == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[2] <= side_d;
      sa_num_q  <= SaNumW'(s_cl) * SaNumW'(in_q.a_inv_mass);
      sa_den_q  <= {1'b0, in_q.a_inv_mass} + {1'b0, in_q.b_inv_mass};
    end
  end

  for (genvar t = 3; t <= TQ; t++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[t] <= side_q[t-1];
      end
    end
  end

  // Share of body A: stiffness * ma / (ma + mb), delayed to meet the root.
  logic [SaQW-1:0] sa_quo;
  logic [SaQW-1:0] sa_dly_q [TSaOut+1:TRoot];

  drcs_div_pipe #(
    .NumW (SaNumW),
    .DenW (SaDenW),
    .QuoW (SaQW)
  ) u_share_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sa_num_q),
    .den_i (sa_den_q),
    .quo_o (sa_quo)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_dly_q[TSaOut+1] <= sa_quo;
    end
  end

  for (genvar t = TSaOut + 2; t <= TRoot; t++) begin : g_sa_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        sa_dly_q[t] <= sa_dly_q[t-1];
      end
    end
  end

  // Stages 3 and 4: squares and their sum.
  logic [SqW-1:0] sq_q [3];
  logic [SqW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= side_q[2].mag[i] * side_q[2].mag[i];
      end
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // Floor square root, one result bit per stage, keeping the remainder
  // sum - root^2 so that each stage needs only a shift and a subtract.
  logic [SqW-1:0]   sq_rem_q  [RootW];
  logic [RootW-1:0] sq_root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int B = RootW - 1 - k;
    logic [SqW-1:0]   rem_in;
    logic [RootW-1:0] root_in;
    logic [TrW-1:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in  = sum_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
    end

    always_comb begin
      trial = (TrW'(root_in) << (B + 1)) + (TrW'(1) << (2 * B));
      take  = ({1'b0, rem_in} >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= take ? SqW'({1'b0, rem_in} - trial) : rem_in;
        sq_root_q[k] <= take ? (root_in | (RootW'(1) << B)) : root_in;
      end
    end
  end

  // Stage E: range check, error and shares.
  logic [RootW-1:0]  d;
  meta_t             meta_d;
  meta_t             meta_q [TE:TQ];
  logic [ErrW-1:0]   err_d, err_q;
  logic [StiffW-1:0] sa_e_q, sb_e_q;
  logic [RootW-1:0]  d_e_q;

  assign d = sq_root_q[RootW-1];

  always_comb begin
    meta_d.grow  = 1'b0;
    err_d        = '0;
    if (d > {1'b0, max_q}) begin
      meta_d.status = drcs_pkg::StatusStretched;
      err_d         = d - {1'b0, max_q};
    end else if (d < {1'b0, min_q}) begin
      meta_d.status = drcs_pkg::StatusCompressed;
      err_d         = {1'b0, min_q} - d;
      meta_d.grow   = 1'b1;
    end else begin
      meta_d.status = drcs_pkg::StatusInRange;
    end
    // A zero separation or two immovable bodies cannot be corrected.
    if (meta_d.status != drcs_pkg::StatusInRange && (d == '0 || side_q[TRoot].mz)) begin
      meta_d.status = drcs_pkg::StatusDegenerate;
    end
    meta_d.apply = (meta_d.status == drcs_pkg::StatusStretched) ||
                   (meta_d.status == drcs_pkg::StatusCompressed);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[TE] <= meta_d;
      err_q      <= err_d;
      sa_e_q     <= sa_dly_q[TRoot];
      sb_e_q     <= s_cl - sa_dly_q[TRoot];
      d_e_q      <= d;
    end
  end

  for (genvar t = TE + 1; t <= TQ; t++) begin : g_meta
    always_ff @(posedge clk_i) begin
      if (en) begin
        meta_q[t] <= meta_q[t-1];
      end
    end
  end

  // Stage F: |delta| * error. Stage G: times each share, and the divisor.
  logic [ProdW-1:0]  p_q [3];
  logic [StiffW-1:0] sa_f_q, sb_f_q;
  logic [RootW-1:0]  d_f_q;
  logic [NumW-1:0]   na_q [3];
  logic [NumW-1:0]   nb_q [3];
  logic [DenW-1:0]   den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i]  <= side_q[TE].mag[i] * err_q;
        na_q[i] <= p_q[i] * sa_f_q;
        nb_q[i] <= p_q[i] * sb_f_q;
      end
      sa_f_q <= sa_e_q;
      sb_f_q <= sb_e_q;
      d_f_q  <= d_e_q;
      den_q  <= {d_f_q, 16'h0000};
    end
  end

  // Correction magnitudes; each is bounded by the error, so QW bits hold it.
  logic [QW-1:0] qa [3];
  logic [QW-1:0] qb [3];

  for (genvar i = 0; i < 3; i++) begin : g_corr
    drcs_div_pipe #(
      .NumW (NumW),
      .DenW (DenW),
      .QuoW (QW)
    ) u_div_a (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (na_q[i]),
      .den_i (den_q),
      .quo_o (qa[i])
    );

    drcs_div_pipe #(
      .NumW (NumW),
      .DenW (DenW),
      .QuoW (QW)
    ) u_div_b (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nb_q[i]),
      .den_i (den_q),
      .quo_o (qb[i])
    );
  end

  // Final stage: apply signed corrections and saturate.
  function automatic logic [PosW-1:0] sat_pos(input logic [ExtW-1:0] v);
    logic ovf;
    ovf = (v[ExtW-1:PosW-1] != {(ExtW-PosW+1){v[ExtW-1]}});
    if (!ovf) begin
      return v[PosW-1:0];
    end
    return v[ExtW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
  endfunction

  side_t                 side_f;
  meta_t                 meta_f;
  logic [2:0][PosW-1:0]  na_res, nb_res;
  logic [ExtW-1:0]       ca, cb, pa_e, pb_e;
  logic                  pos;
  drcs_pkg::out_rsp_t    out_q;

  always_comb begin
    side_f = side_q[TQ];
    meta_f = meta_q[TQ];
    for (int i = 0; i < 3; i++) begin
      ca   = meta_f.apply ? ExtW'(qa[i]) : '0;
      cb   = meta_f.apply ? ExtW'(qb[i]) : '0;
      pos  = (!side_f.neg[i]) == meta_f.grow;
      pa_e = ExtW'($signed(side_f.pa[i]));
      pb_e = ExtW'($signed(side_f.pb[i]));
      na_res[i] = sat_pos(pos ? pa_e + ca : pa_e - ca);
      nb_res[i] = sat_pos(pos ? pb_e - cb : pb_e + cb);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.new_a_x <= na_res[0];
      out_q.new_a_y <= na_res[1];
      out_q.new_a_z <= na_res[2];
      out_q.new_b_x <= nb_res[0];
      out_q.new_b_y <= nb_res[1];
      out_q.new_b_z <= nb_res[2];
      out_q.status  <= meta_f.status;
    end
  end

  assign out_rsp_o = out_q;

endmodule

// ----- verif/distance_range_constraint_solver_checker.sv -----
// Checker for the distance range constraint solver: watches the request,
// response and register channels, predicts each response and compares it.
// Depends on drcs_pkg.
module distance_range_constraint_solver_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  drcs_pkg::in_req_t                 in_req_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  drcs_pkg::out_rsp_t                out_rsp_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [drcs_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [drcs_pkg::CfgDataWidth-1:0] cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam logic [63:0] CorrClamp = 64'd1 << 60;

  logic [drcs_pkg::StiffWidth-1:0] stiffness_q;
  logic [drcs_pkg::DistWidth-1:0]  min_dist_q;
  logic [drcs_pkg::DistWidth-1:0]  max_dist_q;
  drcs_pkg::out_rsp_t              expected_rsp_q[$];

  assign pending_o = expected_rsp_q.size();

  // Exact magnitude of |delta| * share * err / (d * 2^16), truncated and clamped.
  function automatic logic signed [63:0] corr_mag(logic [63:0] mag, logic [63:0] share,
                                                  logic [63:0] err, logic [63:0] sep);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    num = 128'(mag) * 128'(share) * 128'(err);
    den = 128'(sep) << 16;
    quo = num / den;
    if (quo > 128'(CorrClamp)) return CorrClamp;
    return quo[63:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic drcs_pkg::out_rsp_t solve_constraint(drcs_pkg::in_req_t r);
    logic signed [63:0] pa[3];
    logic signed [63:0] pb[3];
    logic signed [63:0] dl[3];
    logic signed [63:0] ca;
    logic signed [63:0] cb;
    logic [63:0]        mag[3];
    logic [127:0]       sq;
    logic [63:0]        sep;
    logic [63:0]        trial;
    logic [63:0]        err;
    logic [63:0]        stiff;
    logic [63:0]        ma;
    logic [63:0]        mb;
    logic [63:0]        sa;
    logic [63:0]        sb;
    logic               grow;
    drcs_pkg::status_e  st;
    drcs_pkg::out_rsp_t rsp;
    pa[0] = $signed(r.a_x); pa[1] = $signed(r.a_y); pa[2] = $signed(r.a_z);
    pb[0] = $signed(r.b_x); pb[1] = $signed(r.b_y); pb[2] = $signed(r.b_z);
    ma = 64'(r.a_inv_mass);
    mb = 64'(r.b_inv_mass);
    stiff = (stiffness_q > drcs_pkg::StiffOne) ? 64'(drcs_pkg::StiffOne) : 64'(stiffness_q);
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = pa[i] - pb[i];
      mag[i] = (dl[i] < 0) ? -dl[i] : dl[i];
      sq += 128'(mag[i]) * 128'(mag[i]);
    end
    // Floor square root, one bit at a time from the top.
    sep = '0;
    for (int b = 50; b >= 0; b--) begin
      trial = sep | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= sq) sep = trial;
    end
    grow = 1'b0;
    err = '0;
    if (sep > 64'(max_dist_q)) begin
      st = drcs_pkg::StatusStretched;
      err = sep - 64'(max_dist_q);
    end else if (sep < 64'(min_dist_q)) begin
      st = drcs_pkg::StatusCompressed;
      err = 64'(min_dist_q) - sep;
      grow = 1'b1;
    end else begin
      st = drcs_pkg::StatusInRange;
    end
    if (st != drcs_pkg::StatusInRange && (sep == 0 || ma + mb == 0))
      st = drcs_pkg::StatusDegenerate;
    if (st == drcs_pkg::StatusStretched || st == drcs_pkg::StatusCompressed) begin
      sa = (stiff * ma) / (ma + mb);
      sb = stiff - sa;
      for (int i = 0; i < 3; i++) begin
        ca = corr_mag(mag[i], sa, err, sep);
        cb = corr_mag(mag[i], sb, err, sep);
        if ((dl[i] >= 0) != grow) begin
          ca = -ca;
          cb = -cb;
        end
        pa[i] += ca;
        pb[i] -= cb;
      end
    end
    rsp.new_a_x = sat32(pa[0]);
    rsp.new_a_y = sat32(pa[1]);
    rsp.new_a_z = sat32(pa[2]);
    rsp.new_b_x = sat32(pb[0]);
    rsp.new_b_y = sat32(pb[1]);
    rsp.new_b_z = sat32(pb[2]);
    rsp.status  = st;
    return rsp;
  endfunction

  function automatic void compare_rsp(drcs_pkg::out_rsp_t exp_rsp,
                                      drcs_pkg::out_rsp_t act_rsp);
    logic [31:0] ev[7];
    logic [31:0] av[7];
    string       names[7];
    names = '{"new_a_x", "new_a_y", "new_a_z", "new_b_x", "new_b_y", "new_b_z", "status"};
    ev = '{exp_rsp.new_a_x, exp_rsp.new_a_y, exp_rsp.new_a_z, exp_rsp.new_b_x,
           exp_rsp.new_b_y, exp_rsp.new_b_z, 32'(exp_rsp.status)};
    av = '{act_rsp.new_a_x, act_rsp.new_a_y, act_rsp.new_a_z, act_rsp.new_b_x,
           act_rsp.new_b_y, act_rsp.new_b_z, 32'(act_rsp.status)};
    for (int i = 0; i < 7; i++) begin
      if (ev[i] !== av[i]) begin
        $display("%0t mismatch %s expected %h actual %h", $time, names[i], ev[i], av[i]);
        fail_count_o++;
      end
    end
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q = drcs_pkg::StiffOne;
      min_dist_q  = '0;
      max_dist_q  = 32'h0001_0000;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t unexpected response, expected none, actual %h", $time, out_rsp_i);
          fail_count_o++;
        end else begin
          compare_rsp(expected_rsp_q.pop_front(), out_rsp_i);
        end
      end
      if (in_valid_i && in_ready_i) expected_rsp_q.push_back(solve_constraint(in_req_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          drcs_pkg::CfgStiffness:   stiffness_q = cfg_data_i[drcs_pkg::StiffWidth-1:0];
          drcs_pkg::CfgMinDistance: min_dist_q  = cfg_data_i;
          drcs_pkg::CfgMaxDistance: max_dist_q  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- verif/tb_distance_range_constraint_solver.sv -----
// Testbench top for the distance range constraint solver: drives requests,
// register writes and response back-pressure, and gives the verdict.
// Depends on drcs_pkg, the block and distance_range_constraint_solver_checker.
module tb_distance_range_constraint_solver;

  localparam int WatchdogLimit = 20000;
  localparam int HoldLen       = 600;
  // A register index with no register behind it.
  localparam logic [drcs_pkg::CfgIdxWidth-1:0] CfgUnusedIdx = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  drcs_pkg::in_req_t                 in_req = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  drcs_pkg::out_rsp_t                out_rsp;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [drcs_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
  logic [drcs_pkg::CfgDataWidth-1:0] cfg_data = '0;
  int                                fail_count;
  int                                pending;
  int                                send_idle_pct = 0;
  int                                recv_stall_pct = 0;
  int                                hold_req = 0;
  int                                hold_seen = 0;
  int                                hold_left = 0;
  int                                quiet_cycles = 0;

  distance_range_constraint_solver u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  distance_range_constraint_solver_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("distance_range_constraint_solver verification failed");
      $finish;
    end
  end

  task automatic send_req(drcs_pkg::in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Drops cfg_valid after each write and waits for the next falling edge, so back-to-back
  // calls never drive cfg_valid twice at the same falling edge.
  task automatic write_reg(logic [drcs_pkg::CfgIdxWidth-1:0] idx,
                           logic [drcs_pkg::CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_range(logic [31:0] stiff, logic [31:0] dmin, logic [31:0] dmax);
    drain();
    write_reg(drcs_pkg::CfgStiffness, stiff);
    write_reg(drcs_pkg::CfgMinDistance, dmin);
    write_reg(drcs_pkg::CfgMaxDistance, dmax);
  endtask

  function automatic drcs_pkg::in_req_t make_req(logic [31:0] ax, logic [31:0] ay,
                                                 logic [31:0] az, logic [31:0] bx,
                                                 logic [31:0] by, logic [31:0] bz,
                                                 logic [31:0] ma, logic [31:0] mb);
    drcs_pkg::in_req_t r;
    r = '{ax, ay, az, bx, by, bz, ma, mb};
    return r;
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(5))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(1 << 18);
    endcase
  endfunction

  // Mostly pairs whose separation lands near the configured range.
  function automatic drcs_pkg::in_req_t rand_req();
    drcs_pkg::in_req_t r;
    int                kind;
    int                shift;
    logic [31:0]       off[3];
    kind = $urandom_range(9);
    shift = $urandom_range(11, 17);
    r.b_x = $urandom; r.b_y = $urandom; r.b_z = $urandom;
    for (int i = 0; i < 3; i++) begin
      off[i] = $signed($urandom) >>> shift;
    end
    r.a_x = r.b_x + off[0];
    r.a_y = r.b_y + off[1];
    r.a_z = r.b_z + off[2];
    if (kind == 0) begin
      r.a_x = $urandom; r.a_y = $urandom; r.a_z = $urandom;
    end else if (kind == 1) begin
      r.a_x = r.b_x; r.a_y = r.b_y; r.a_z = r.b_z;
    end
    r.a_inv_mass = rand_mass();
    r.b_inv_mass = rand_mass();
    return r;
  endfunction

  task automatic directed_set();
    send_req(make_req(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000));
    send_req(make_req(32'h8000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000));
    send_req(make_req(32'h50000, 32'hFFFD0000, 32'h1234, 0, 0, 0, 32'h10000, 32'h30000));
    send_req(make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_req(make_req(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 0,
                      32'hFFFFFFFF, 0));
    send_req(make_req(32'h40000, 32'h40000, 0, 0, 0, 0, 0, 0));
    send_req(make_req(32'h20000, 0, 32'h20000, 32'h10000, 0, 0, 0, 32'h8000));
    send_req(make_req(32'h1000, 32'h1000, 32'h1000, 32'h1000, 32'h1000, 32'h1000,
                      32'h10000, 32'h10000));
    send_req(make_req(32'h10, 32'hFFFFFFF0, 32'h0, 0, 0, 0, 32'h1, 32'h1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset defaults, then a proper range, then inverted ranges, the register extremes and the unused index.
    directed_set();
    set_range(32'h10000, 32'h30000, 32'h40000);
    directed_set();
    set_range(32'h1FFFF, 32'hFFFFFFFF, 32'h0);
    directed_set();
    set_range(32'h0, 32'h50000, 32'h20000);
    directed_set();
    drain();
    write_reg(CfgUnusedIdx, 32'hFFFFFFFF);
    write_reg(drcs_pkg::CfgMaxDistance, 32'hFFFFFFFF);
    directed_set();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (phase == 7)
        set_range(32'h10000, 32'h0, 32'hFFFFFFFF);
      else if ($urandom_range(3) == 0)
        set_range($urandom_range(32'h1FFFF), $urandom_range(1 << 22), $urandom_range(1 << 19));
      else
        set_range($urandom_range(3) == 0 ? 32'h10000 : $urandom_range(32'h1FFFF),
                  $urandom_range(1 << 20), (1 << 20) + $urandom_range(1 << 21));
      for (int n = 0; n < 165; n++) begin
        if (phase == 0 && n == 20) hold_req++;
        if (phase == 3 && n == 80) drain();
        send_req(rand_req());
      end
    end

    drain();
    if (fail_count == 0)
      $display("distance_range_constraint_solver verification clean");
    else
      $display("distance_range_constraint_solver verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/drcs_pkg.sv
src/drcs_div_pipe.sv
src/distance_range_constraint_solver.sv
verif/distance_range_constraint_solver_checker.sv
verif/tb_distance_range_constraint_solver.sv
